[design/three_lfsr_majority_stream_cipher_core_defines.svh]
// ----------------------------------------------------------------------------
// Stream cipher core assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef THREE_LFSR_MAJORITY_STREAM_CIPHER_CORE_DEFINES_SVH
`define THREE_LFSR_MAJORITY_STREAM_CIPHER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TLMSC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlmsc same-cycle check failed");

// next-cycle implication, disabled in reset
`define TLMSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlmsc next-cycle check failed");

`endif

[design/tlmsc_pkg.sv]
// ----------------------------------------------------------------------------
// Stream cipher package
// Widths, tap polynomials, codes and the LFSR step function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tlmsc_pkg;

  localparam int DataW   = 8;
  localparam int KeyLowW = 64;
  localparam int KeyHiW  = 16;
  localparam int CfgW    = 64;
  localparam int LenA    = 17;
  localparam int LenB    = 19;
  localparam int LenC    = 42;
  localparam int StepW   = 42;
  localparam int Steps   = 8;

  localparam logic [StepW-1:0] PolyA = 42'h0000000EF75;
  localparam logic [StepW-1:0] PolyB = 42'h00000058C2F;
  localparam logic [StepW-1:0] PolyC = 42'h1E7B4EED1DF;
  localparam logic [StepW-1:0] TopA  = 42'h00000010000;
  localparam logic [StepW-1:0] TopB  = 42'h00000040000;
  localparam logic [StepW-1:0] TopC  = 42'h20000000000;

  // majority of three bits, index {c, b, a}
  localparam logic [7:0] MajorityTab = 8'b1110_1000;

  typedef enum logic [0:0] {
    FUNC_RELOAD = 1'b0,
    FUNC_DATA   = 1'b1
  } func_t;

  typedef enum logic [0:0] {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic step;
  } lfsr_ctl_t;

  function automatic logic [StepW-1:0] lfsr_advance(input logic [StepW-1:0] r,
                                                    input logic [StepW-1:0] poly,
                                                    input logic [StepW-1:0] top);
    logic fb;
    fb = ^(r & poly);
    return (r >> 1) | (fb ? top : '0);
  endfunction

endpackage

`default_nettype wire

[design/tlmsc_ifs.sv]
// ----------------------------------------------------------------------------
// Stream cipher channels
// Valid/ready interfaces for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tlmsc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [tlmsc_pkg::DataW-1:0] data_in;

  modport source (output valid, output func, output data_in, input ready);
  modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface tlmsc_out_if;
  logic                       valid;
  logic                       ready;
  logic [tlmsc_pkg::DataW-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

[design/three_lfsr_majority_stream_cipher_core.sv]
// ----------------------------------------------------------------------------
// Three-LFSR majority stream cipher core
//
//   channel   direction  payload            handshake
//   in_ch     sink       func, data_in      valid/ready
//   out_ch    source     data_out           valid/ready
//   cfg       write      cfg_index, cfg_data cfg_we
//
// One item per cycle sustained while out_ch is not stalled; an accepted input
// passes the input register, then the result register, before its result is
// valid. The LFSR bank does all eight steps of a data item in the cycle it
// leaves the input register.
// Synchronous reset clears the key, the LFSRs and both valid flags.
// A stalled result holds in the result register while the input register
// still takes one more item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_lfsr_majority_stream_cipher_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [tlmsc_pkg::CfgW-1:0] cfg_data,
  tlmsc_in_if.sink                        in_ch,
  tlmsc_out_if.source                     out_ch
);

  logic                             s1_valid;
  tlmsc_pkg::func_t                 s1_func;
  logic [tlmsc_pkg::DataW-1:0]      s1_data;
  logic                             s1_adv;
  logic                             out_valid;
  logic [tlmsc_pkg::DataW-1:0]      out_data;
  logic [tlmsc_pkg::KeyLowW-1:0]    key_low;
  logic [tlmsc_pkg::KeyHiW-1:0]     key_high;
  logic [tlmsc_pkg::DataW-1:0]      ks;
  tlmsc_pkg::lfsr_ctl_t             ctl;

  tlmsc_key_regs u_key_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_low   (key_low),
    .key_high  (key_high)
  );

  tlmsc_lfsr_bank u_lfsr_bank (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .key_low  (key_low),
    .key_high (key_high),
    .ks       (ks)
  );

  assign s1_adv      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || s1_adv;

  assign ctl.load = s1_adv && (s1_func == tlmsc_pkg::FUNC_RELOAD);
  assign ctl.step = s1_adv && (s1_func == tlmsc_pkg::FUNC_DATA);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_func <= tlmsc_pkg::func_t'(in_ch.func);
      s1_data <= in_ch.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ch.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= (s1_func == tlmsc_pkg::FUNC_DATA) ? (s1_data ^ ks) : '0;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.data_out = out_data;

endmodule

`default_nettype wire

[design/tlmsc_key_regs.sv]
// ----------------------------------------------------------------------------
// Stream cipher key registers
// Decode configuration writes into the low and high key words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlmsc_key_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [tlmsc_pkg::CfgW-1:0]    cfg_data,
  output logic      [tlmsc_pkg::KeyLowW-1:0] key_low,
  output logic      [tlmsc_pkg::KeyHiW-1:0]  key_high
);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      unique case (tlmsc_pkg::cfg_reg_t'(cfg_index))
        tlmsc_pkg::REG_KEY_LOW:  key_low  <= cfg_data;
        tlmsc_pkg::REG_KEY_HIGH: key_high <= cfg_data[tlmsc_pkg::KeyHiW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/tlmsc_lfsr_bank.sv]
// ----------------------------------------------------------------------------
// Stream cipher LFSR bank
// Three LFSRs, eight steps per data item, majority keystream byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tlmsc_lfsr_bank (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tlmsc_pkg::lfsr_ctl_t          ctl,
  input  wire logic [tlmsc_pkg::KeyLowW-1:0] key_low,
  input  wire logic [tlmsc_pkg::KeyHiW-1:0]  key_high,
  output logic      [tlmsc_pkg::DataW-1:0]   ks
);

  logic [tlmsc_pkg::LenA-1:0] shift_a;
  logic [tlmsc_pkg::LenB-1:0] shift_b;
  logic [tlmsc_pkg::LenC-1:0] shift_c;
  logic [tlmsc_pkg::LenA-1:0] shift_a_next;
  logic [tlmsc_pkg::LenB-1:0] shift_b_next;
  logic [tlmsc_pkg::LenC-1:0] shift_c_next;
  logic [tlmsc_pkg::KeyLowW+tlmsc_pkg::KeyHiW-1:0] key;

  assign key = {key_high, key_low};

  always_comb begin
    logic [tlmsc_pkg::StepW-1:0] a;
    logic [tlmsc_pkg::StepW-1:0] b;
    logic [tlmsc_pkg::StepW-1:0] c;
    a  = tlmsc_pkg::StepW'(shift_a);
    b  = tlmsc_pkg::StepW'(shift_b);
    c  = tlmsc_pkg::StepW'(shift_c);
    ks = '0;
    for (int i = 0; i < tlmsc_pkg::Steps; i++) begin
      ks[i] = tlmsc_pkg::MajorityTab[{c[0], b[0], a[0]}];
      a = tlmsc_pkg::lfsr_advance(a, tlmsc_pkg::PolyA, tlmsc_pkg::TopA);
      b = tlmsc_pkg::lfsr_advance(b, tlmsc_pkg::PolyB, tlmsc_pkg::TopB);
      c = tlmsc_pkg::lfsr_advance(c, tlmsc_pkg::PolyC, tlmsc_pkg::TopC);
    end
    shift_a_next = a[tlmsc_pkg::LenA-1:0];
    shift_b_next = b[tlmsc_pkg::LenB-1:0];
    shift_c_next = c[tlmsc_pkg::LenC-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_a <= '0;
      shift_b <= '0;
      shift_c <= '0;
    end else if (ctl.load) begin
      shift_a <= key[tlmsc_pkg::LenA-1:0];
      shift_b <= key[tlmsc_pkg::LenA+tlmsc_pkg::LenB-1:tlmsc_pkg::LenA];
      shift_c <= key[tlmsc_pkg::LenA+tlmsc_pkg::LenB+tlmsc_pkg::LenC-1:
                     tlmsc_pkg::LenA+tlmsc_pkg::LenB];
    end else if (ctl.step) begin
      shift_a <= shift_a_next;
      shift_b <= shift_b_next;
      shift_c <= shift_c_next;
    end
  end

endmodule

`default_nettype wire

[design/tlmsc_checker.sv]
// ----------------------------------------------------------------------------
// Stream cipher port checker
// Port-level checks on flow and latency, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "three_lfsr_majority_stream_cipher_core_defines.svh"

module tlmsc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tlmsc_pkg::DataW-1:0] data_out
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

`TLMSC_ASSERT_NEXT(a_hold_stall, clk, rst, out_valid && !out_ready, out_valid && $stable(data_out))
`TLMSC_ASSERT_SAME(a_ready_when_out_empty, clk, rst, !out_valid, in_ready)
`TLMSC_ASSERT_SAME(a_rise_after_accept, clk, rst, $rose(out_valid), $past(in_acc, 2))
`TLMSC_ASSERT_NEXT(a_out_follows_accept, clk, rst, in_acc && !out_valid, out_valid || in_ready)

endmodule

bind three_lfsr_majority_stream_cipher_core tlmsc_checker u_tlmsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .data_out  (out_ch.data_out)
);

`default_nettype wire
